FILE: rtl/core/fds_pkg.sv
package fds_pkg;

  // Fixed field widths
  localparam int READING_W  = 64;
  localparam int FRAME_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SMOOTH_W   = 4;
  localparam int WIN_W      = SMOOTH_W + 1;
  localparam int WIN_MAX    = 2 ** SMOOTH_W;

  // Parameter defaults
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int DELTA_WIDTH_DEF   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_EXTRA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE          = 2'd3;

  // Input command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_RESET,
    OP_FIXED,
    OP_ELAPSED,
    OP_DELTA,
    OP_HOLD,
    OP_STORE,
    OP_SUM,
    OP_DIV_INIT,
    OP_DIV,
    OP_MEAN,
    OP_OUT
  } fds_op_e;

  typedef struct packed {
    fds_op_e op;
  } fds_cmd_t;

  typedef struct packed {
    logic is_reset;
    logic enabled;
    logic fixed_mode;
    logic smooth_on;
    logic sum_done;
    logic div_done;
  } fds_status_t;

endpackage

FILE: rtl/core/fds_if.sv
// Input channel: one event per transaction
interface fds_in_if import fds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [READING_W-1:0] counter_value;

  modport source (output valid, command, counter_value, input ready);
  modport sink   (input valid, command, counter_value, output ready);
endinterface

// Output channel: one report per transaction
interface fds_out_if import fds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FRAME_W-1:0]   frame_ticks;
  logic [READING_W-1:0] elapsed_ticks;

  modport source (output valid, frame_ticks, elapsed_ticks, input ready);
  modport sink   (input valid, frame_ticks, elapsed_ticks, output ready);
endinterface

FILE: rtl/core/frame_delta_smoother.sv
// Frame period measurement with a moving average. Each input transaction is
// either a reset (captures the counter reading as the new base and clears the
// elapsed time, the held frame value and the history) or an update, and each
// produces exactly one output transaction with the held frame duration and the
// elapsed time since the base, both in counter ticks. One event at a time is
// processed: a reset, a disabled update or a fixed-step update goes from
// decode straight to finish; a measured update without smoothing also takes
// the elapsed, delta and hold steps; with smoothing it stores the delta, sums
// the window (W = window length, up to 16) by a sequential read of the history
// RAM and forms the mean by a one-bit-per-cycle divide of the sum by W. A new
// event is accepted as soon as the previous result sits in the output
// register. Configuration must only be written while no event is in
// flight.
module frame_delta_smoother import fds_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int DELTA_WIDTH   = DELTA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fds_in_if.sink                in_if,
  fds_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  fds_cmd_t    cmd;
  fds_status_t status;

  fds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fds_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .DELTA_WIDTH   (DELTA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (in_if.command),
    .counter_value_i (in_if.counter_value),
    .cmd_i           (cmd),
    .status_o        (status),
    .frame_ticks_o   (out_if.frame_ticks),
    .elapsed_ticks_o (out_if.elapsed_ticks)
  );

endmodule

FILE: rtl/core/fds_ram.sv
module fds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fds_ctrl.sv
module fds_ctrl import fds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  fds_status_t status_i,
  output fds_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DELTA,
    S_STORE,
    S_SUM,
    S_DIV,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  fds_op_e op;

  // Sequence the datapath through one event
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    op          = OP_NONE;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_CAPTURE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_reset) begin
          op      = OP_RESET;
          state_d = S_FINISH;
        end else if (!status_i.enabled) begin
          state_d = S_FINISH;
        end else if (status_i.fixed_mode) begin
          op      = OP_FIXED;
          state_d = S_FINISH;
        end else begin
          op      = OP_ELAPSED;
          state_d = S_DELTA;
        end
      end
      S_DELTA: begin
        op      = OP_DELTA;
        state_d = S_STORE;
      end
      S_STORE: begin
        if (status_i.smooth_on) begin
          op      = OP_STORE;
          state_d = S_SUM;
        end else begin
          op      = OP_HOLD;
          state_d = S_FINISH;
        end
      end
      S_SUM: begin
        if (status_i.sum_done) begin
          op      = OP_DIV_INIT;
          state_d = S_DIV;
        end else begin
          op = OP_SUM;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          op      = OP_MEAN;
          state_d = S_FINISH;
        end else begin
          op = OP_DIV;
        end
      end
      S_FINISH: begin
        // Load the result once the output register is free
        if (!out_valid_q || out_ready_i) begin
          op          = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;

endmodule

FILE: rtl/core/fds_datapath.sv
module fds_datapath import fds_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int DELTA_WIDTH   = DELTA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  command_i,
  input  logic [READING_W-1:0]  counter_value_i,
  input  fds_cmd_t              cmd_i,
  output fds_status_t           status_o,
  output logic [FRAME_W-1:0]    frame_ticks_o,
  output logic [READING_W-1:0]  elapsed_ticks_o
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int CMP_W  = (SLOT_W > WIN_W) ? SLOT_W : WIN_W;
  localparam int SUM_W  = DELTA_WIDTH + SMOOTH_W;
  localparam int DCNT_W = $clog2(DELTA_WIDTH + 1);
  localparam int HD_CAP = (HISTORY_DEPTH < WIN_MAX) ? HISTORY_DEPTH : WIN_MAX;
  localparam logic [READING_W-1:0] DELTA_MAX =
    (READING_W'(1) << DELTA_WIDTH) - READING_W'(1);

  function automatic logic [DELTA_WIDTH-1:0] sat_delta(input logic [READING_W-1:0] v);
    logic [READING_W-1:0] s;
    s = (v > DELTA_MAX) ? DELTA_MAX : v;
    return DELTA_WIDTH'(s);
  endfunction

  // Configuration registers
  logic [SMOOTH_W-1:0]   smooth_extra_q;
  logic [CFG_DATA_W-1:0] fixed_step_q;
  logic [CFG_DATA_W-1:0] min_frame_q;
  logic                  enable_q;

  // Measurement state
  logic                     cmd_q;
  logic [READING_W-1:0]     reading_q;
  logic [READING_W-1:0]     base_q;
  logic [READING_W-1:0]     elapsed_now_q;
  logic [READING_W-1:0]     elapsed_last_q;
  logic [DELTA_WIDTH-1:0]   held_q;
  logic [DELTA_WIDTH-1:0]   delta_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [HISTORY_DEPTH-1:0] hist_valid_q;

  // Window sum and divider
  logic [WIN_W-1:0]       rd_cnt_q;
  logic                   rd_vld_q;
  logic                   rd_hit_q;
  logic [SUM_W-1:0]       acc_q;
  logic [SMOOTH_W-1:0]    rem_q;
  logic [DELTA_WIDTH-1:0] quo_q;
  logic [DCNT_W-1:0]      div_cnt_q;

  // Output payload
  logic [FRAME_W-1:0]   frame_out_q;
  logic [READING_W-1:0] elapsed_out_q;

  logic [WIN_W-1:0]       win;
  logic [WIN_W-1:0]       ext1;
  logic [READING_W-1:0]   fixed_sum;
  logic [READING_W-1:0]   diff;
  logic [DELTA_WIDTH-1:0] floor_v;
  logic [DELTA_WIDTH-1:0] store_v;
  logic [SLOT_W-1:0]      slot_eff;
  logic [CMP_W-1:0]       slot_inc;
  logic [SLOT_W-1:0]      slot_next;
  logic                   rd_issue;
  logic [SLOT_W-1:0]      rd_addr;
  logic [DELTA_WIDTH-1:0] rd_data;
  logic                   ram_we;
  logic [WIN_W-1:0]       div_t;
  logic                   div_ge;

  // Window length limited to the store
  always_comb begin
    ext1 = WIN_W'(smooth_extra_q) + WIN_W'(1);
    win  = (ext1 > WIN_W'(HD_CAP)) ? WIN_W'(HD_CAP) : ext1;
  end

  // Per-operation combinational terms
  always_comb begin
    fixed_sum = elapsed_now_q + READING_W'(fixed_step_q);
    diff      = elapsed_now_q - elapsed_last_q;
    floor_v   = sat_delta(READING_W'(min_frame_q));
    store_v   = (delta_q < floor_v) ? floor_v : delta_q;
    slot_eff  = (CMP_W'(slot_q) >= CMP_W'(win)) ? '0 : slot_q;
    slot_inc  = CMP_W'(slot_eff) + CMP_W'(1);
    slot_next = (slot_inc >= CMP_W'(win)) ? '0 : SLOT_W'(slot_inc);
    rd_issue  = (cmd_i.op == OP_SUM) && (rd_cnt_q < win);
    rd_addr   = SLOT_W'(rd_cnt_q);
    ram_we    = (cmd_i.op == OP_STORE);
    div_t     = {rem_q, quo_q[DELTA_WIDTH-1]};
    div_ge    = (div_t >= win);
  end

  fds_ram #(
    .WIDTH (DELTA_WIDTH),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_eff),
    .wdata_i (store_v),
    .re_i    (rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_extra_q <= '0;
      fixed_step_q   <= '0;
      min_frame_q    <= CFG_DATA_W'(1);
      enable_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SMOOTHING_EXTRA: smooth_extra_q <= cfg_data_i[SMOOTH_W-1:0];
        CFG_FIXED_STEP:      fixed_step_q   <= cfg_data_i;
        CFG_MIN_FRAME:       min_frame_q    <= cfg_data_i;
        CFG_ENABLE:          enable_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Measurement state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q         <= '0;
      elapsed_now_q  <= '0;
      elapsed_last_q <= '0;
      held_q         <= '0;
      slot_q         <= '0;
      hist_valid_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_RESET: begin
          base_q         <= reading_q;
          elapsed_now_q  <= '0;
          elapsed_last_q <= '0;
          held_q         <= '0;
          slot_q         <= '0;
          hist_valid_q   <= '0;
        end
        OP_FIXED: begin
          elapsed_now_q  <= fixed_sum;
          elapsed_last_q <= fixed_sum;
          held_q         <= sat_delta(READING_W'(fixed_step_q));
        end
        OP_ELAPSED: begin
          elapsed_now_q <= reading_q - base_q;
        end
        OP_DELTA: begin
          elapsed_last_q <= elapsed_now_q;
        end
        OP_HOLD: begin
          held_q <= delta_q;
        end
        OP_STORE: begin
          hist_valid_q[slot_eff] <= 1'b1;
          slot_q                 <= slot_next;
        end
        OP_MEAN: begin
          held_q <= quo_q;
        end
        default: ;
      endcase
    end
  end

  // Capture, delta, window sum and divider payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        cmd_q     <= command_i;
        reading_q <= counter_value_i;
      end
      OP_DELTA: begin
        delta_q <= diff[READING_W-1] ? '0 : sat_delta(diff);
      end
      OP_STORE: begin
        rd_cnt_q <= '0;
        rd_vld_q <= 1'b0;
        acc_q    <= '0;
      end
      OP_SUM: begin
        if (rd_issue) begin
          rd_cnt_q <= rd_cnt_q + WIN_W'(1);
          rd_hit_q <= hist_valid_q[rd_addr];
        end
        rd_vld_q <= rd_issue;
        if (rd_vld_q && rd_hit_q) begin
          acc_q <= acc_q + SUM_W'(rd_data);
        end
      end
      OP_DIV_INIT: begin
        rem_q     <= acc_q[SUM_W-1:DELTA_WIDTH];
        quo_q     <= acc_q[DELTA_WIDTH-1:0];
        div_cnt_q <= '0;
      end
      OP_DIV: begin
        rem_q     <= div_ge ? SMOOTH_W'(div_t - win) : div_t[SMOOTH_W-1:0];
        quo_q     <= {quo_q[DELTA_WIDTH-2:0], div_ge};
        div_cnt_q <= div_cnt_q + DCNT_W'(1);
      end
      OP_OUT: begin
        frame_out_q   <= FRAME_W'(held_q);
        elapsed_out_q <= elapsed_now_q;
      end
      default: ;
    endcase
  end

  assign status_o.is_reset   = (cmd_q == CMD_RESET);
  assign status_o.enabled    = enable_q;
  assign status_o.fixed_mode = (fixed_step_q != '0);
  assign status_o.smooth_on  = (smooth_extra_q != '0);
  assign status_o.sum_done   = (rd_cnt_q == win) && !rd_vld_q;
  assign status_o.div_done   = (div_cnt_q == DCNT_W'(DELTA_WIDTH));

  assign frame_ticks_o   = frame_out_q;
  assign elapsed_ticks_o = elapsed_out_q;

endmodule
